>>> src/ualc_pkg.sv
// ----------------------------------------------------------------------------
// ualc_pkg
// shared types and constants for the uart adc link controller
// ----------------------------------------------------------------------------
`default_nettype none

package ualc_pkg;

    // link constants
    localparam logic [7:0]  SYNC_TX_BYTE   = 8'hAA;
    localparam logic [7:0]  SYNC_RX_BYTE   = 8'h55;
    localparam logic [7:0]  HIGH_CODE_MASK = 8'b0000_1111;
    localparam logic [7:0]  LOW_CODE_MASK  = 8'b0111_1110;
    localparam int unsigned CODE_W         = 10;
    localparam int unsigned VREF_W         = 10;
    localparam int unsigned VOLT_W         = 10;
    localparam int unsigned TICK_W         = 16;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // register defaults
    localparam logic [7:0]        CFG_BASE_RST     = 8'd0;
    localparam logic [TICK_W-1:0] INIT_TIMEOUT_RST = 16'd1000;
    localparam logic [TICK_W-1:0] READ_TIMEOUT_RST = 16'd10;
    localparam logic [VREF_W-1:0] VREF_RST         = 10'd330;

    // register indexes
    typedef enum logic [1:0] {
        REG_CONFIG_BASE  = 2'd0,
        REG_INIT_TIMEOUT = 2'd1,
        REG_READ_TIMEOUT = 2'd2,
        REG_VREF         = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        OP_START_SYNC = 2'd0,
        OP_START_READ = 2'd1,
        OP_RX_BYTE    = 2'd2,
        OP_TICK       = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_SYNC_TIMEOUT = 2'd1,
        ST_READ_TIMEOUT = 2'd2,
        ST_NOT_READY    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_HANDSHAKE = 3'd1,
        PH_ECHO      = 3'd2,
        PH_HIGH      = 3'd3,
        PH_LOW       = 3'd4
    } t_phase;

    typedef struct packed {
        logic [1:0] operation;
        logic [1:0] channel;
        logic [7:0] rx_byte;
    } t_in_beat;

    typedef struct packed {
        logic              tx_valid;
        logic [7:0]        tx_byte;
        logic              done_res;
        logic [1:0]        status;
        logic [VOLT_W-1:0] voltage;
        logic              link_ready;
    } t_out_beat;

endpackage

`default_nettype wire

>>> src/uart_adc_link_controller_top.sv
// ----------------------------------------------------------------------------
// uart_adc_link_controller_top
// host side control of a uart linked isolated converter: baud sync and reads
// ----------------------------------------------------------------------------
// the result beat of an accepted input beat is registered and shown in the cycle after
// throughput: one input beat per cycle; the single result register is the
//   only buffer, so input stalls only while that register is full and stalled
// reset (synchronous, active low): link idle, not ready, tick counter cleared,
//   registers back to their defaults, result register empty
`default_nettype none

module uart_adc_link_controller_top
    import ualc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // event channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_beat    i_in_data,

    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_beat        o_out_data,

    // register write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [7:0]        r_cfg_base;
    logic [TICK_W-1:0] r_init_timeout;
    logic [TICK_W-1:0] r_read_timeout;
    logic [VREF_W-1:0] r_vref;

    // writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base     <= CFG_BASE_RST;
            r_init_timeout <= INIT_TIMEOUT_RST;
            r_read_timeout <= READ_TIMEOUT_RST;
            r_vref         <= VREF_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_CONFIG_BASE:  r_cfg_base     <= i_cfg_data[7:0];
                REG_INIT_TIMEOUT: r_init_timeout <= i_cfg_data[TICK_W-1:0];
                REG_READ_TIMEOUT: r_read_timeout <= i_cfg_data[TICK_W-1:0];
                REG_VREF:         r_vref         <= i_cfg_data[VREF_W-1:0];
                default:          r_vref         <= r_vref;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake: the result register parts the two sides, so a new beat
    // goes in whenever that register is empty or being drained
    // ------------------------------------------------------------------
    logic      r_out_valid;
    t_out_beat r_out;
    logic      w_in_take;
    logic      w_out_take;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_in_take   = i_in_valid && !o_in_stall;
    assign w_out_take  = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // link state
    // ------------------------------------------------------------------
    t_phase            r_phase,   n_phase;
    logic              r_sync,    n_sync;     // previous sync byte was 0x55
    logic              r_ready,   n_ready;    // sticky link ready flag
    logic [TICK_W-1:0] r_elapsed, n_elapsed;  // ticks in current operation
    logic [7:0]        r_cmd,     n_cmd;      // command byte sent for the read
    logic [7:0]        r_high,    n_high;     // first data byte of the read

    // decoded event fields
    t_op        w_op;
    logic [7:0] w_cmd_byte;
    logic       w_sync_hit;
    logic       w_busy;

    assign w_op       = t_op'(i_in_data.operation);
    assign w_cmd_byte = r_cfg_base | {2'b00, i_in_data.channel, 4'b0000};
    assign w_sync_hit = (i_in_data.rx_byte == SYNC_RX_BYTE);
    assign w_busy     = (r_phase != PH_IDLE);

    // saturating tick count after this tick
    logic [TICK_W-1:0] w_tick_cnt;
    logic              w_sync_expired;
    logic              w_read_expired;

    assign w_tick_cnt     = (r_elapsed == TICK_MAX) ? r_elapsed : r_elapsed + 1'b1;
    assign w_sync_expired = (w_tick_cnt >= r_init_timeout);
    assign w_read_expired = (w_tick_cnt >= r_read_timeout);

    // conversion: 10-bit code scaled by vref, divided by 1024 as a shift
    logic [CODE_W-1:0]        w_code;
    logic [CODE_W+VREF_W-1:0] w_product;
    logic [7:0]               w_hi_bits;
    logic [7:0]               w_lo_bits;

    assign w_hi_bits = r_high & HIGH_CODE_MASK;
    assign w_lo_bits = i_in_data.rx_byte & LOW_CODE_MASK;
    assign w_code    = {w_hi_bits[3:0], w_lo_bits[6:1]};
    assign w_product = (CODE_W+VREF_W)'(w_code) * (CODE_W+VREF_W)'(r_vref);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_phase   = r_phase;
        n_sync    = r_sync;
        n_ready   = r_ready;
        n_elapsed = r_elapsed;
        n_cmd     = r_cmd;
        n_high    = r_high;
        unique case (w_op)
            OP_START_SYNC: begin
                // any operation in progress is dropped
                n_phase   = PH_HANDSHAKE;
                n_sync    = 1'b0;
                n_elapsed = '0;
            end
            OP_START_READ: begin
                // not ready: rejected at once, a running handshake carries on
                if (r_ready) begin
                    n_cmd     = w_cmd_byte;
                    n_phase   = PH_ECHO;
                    n_elapsed = '0;
                end
            end
            OP_RX_BYTE: begin
                unique case (r_phase)
                    PH_HANDSHAKE: begin
                        n_sync = w_sync_hit;
                        if (w_sync_hit && r_sync) begin
                            n_ready = 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_ECHO: begin
                        // skip bytes until our own command comes back
                        if (i_in_data.rx_byte == r_cmd) begin
                            n_phase = PH_HIGH;
                        end
                    end
                    PH_HIGH: begin
                        n_high  = i_in_data.rx_byte;
                        n_phase = PH_LOW;
                    end
                    PH_LOW: begin
                        n_phase = PH_IDLE;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
            OP_TICK: begin
                if (w_busy) begin
                    n_elapsed = w_tick_cnt;
                    priority if (r_phase == PH_HANDSHAKE) begin
                        if (w_sync_expired) begin
                            n_phase = PH_IDLE;
                        end
                    end else if (w_read_expired) begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // result beat
    // ------------------------------------------------------------------
    t_out_beat n_out;

    always_comb begin
        n_out            = '0;
        n_out.link_ready = n_ready;
        unique case (w_op)
            OP_START_SYNC: begin
                n_out.tx_valid = 1'b1;
                n_out.tx_byte  = SYNC_TX_BYTE;
            end
            OP_START_READ: begin
                if (r_ready) begin
                    n_out.tx_valid = 1'b1;
                    n_out.tx_byte  = w_cmd_byte;
                end else begin
                    n_out.done_res = 1'b1;
                    n_out.status   = ST_NOT_READY;
                end
            end
            OP_RX_BYTE: begin
                unique case (r_phase)
                    PH_HANDSHAKE: begin
                        // every byte during sync is answered with another 0xAA
                        n_out.tx_valid = 1'b1;
                        n_out.tx_byte  = SYNC_TX_BYTE;
                        n_out.done_res = w_sync_hit && r_sync;
                    end
                    PH_LOW: begin
                        n_out.done_res = 1'b1;
                        n_out.voltage  = w_product[CODE_W+VREF_W-1:CODE_W];
                    end
                    default: begin
                        n_out.done_res = 1'b0;
                    end
                endcase
            end
            OP_TICK: begin
                if (w_busy) begin
                    priority if (r_phase == PH_HANDSHAKE) begin
                        if (w_sync_expired) begin
                            n_out.done_res = 1'b1;
                            n_out.status   = ST_SYNC_TIMEOUT;
                        end
                    end else if (w_read_expired) begin
                        n_out.done_res = 1'b1;
                        n_out.status   = ST_READ_TIMEOUT;
                    end
                end
            end
            default: begin
                n_out.done_res = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_sync    <= 1'b0;
            r_ready   <= 1'b0;
            r_elapsed <= '0;
            r_cmd     <= '0;
            r_high    <= '0;
        end else if (w_in_take) begin
            r_phase   <= n_phase;
            r_sync    <= n_sync;
            r_ready   <= n_ready;
            r_elapsed <= n_elapsed;
            r_cmd     <= n_cmd;
            r_high    <= n_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_take) begin
            r_out_valid <= 1'b1;
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload loads with each accepted beat
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_out <= n_out;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // the ready flag never drops once the link is up
    a_ready_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |=> r_ready)
        else $error("link ready flag dropped");

    // a finished operation (other than a rejected read) leaves the link idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_take && n_out.done_res && n_out.status != ST_NOT_READY)
        |=> (r_phase == PH_IDLE))
        else $error("operation finished but phase not idle");

    // an accepted beat always shows up in the result register next cycle
    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> r_out_valid)
        else $error("accepted beat produced no result");

    // a voltage only comes with a successful completion
    a_volt_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.voltage != '0)
        |-> (r_out.done_res && r_out.status == ST_OK))
        else $error("voltage without a completed read");

    // the tick counter is reset by every start beat that opens an operation; this check covers the handshake start
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_take && w_op == OP_START_SYNC) |=> (r_elapsed == '0))
        else $error("tick counter not cleared on handshake start");

endmodule

`default_nettype wire
